// ----- src/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants of the segment collision table.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

	localparam int CoordW  = 16;              // coordinate width
	localparam int DiffW   = CoordW + 1;      // endpoint difference
	localparam int ProdW   = 2 * DiffW;       // one cross-product term
	localparam int WideW   = ProdW + 1;       // difference of two terms
	localparam int OutCntW = 7;               // count fields of a result
	localparam int XLat    = 3;               // stages in the intersection unit

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [DiffW-1:0]  diff_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [WideW-1:0]  wide_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_t;

	typedef struct packed {
		logic               segment_added;
		logic [OutCntW-1:0] removed_count;
		logic [OutCntW-1:0] occupancy;
		logic               table_full;
	} res_t;

	typedef struct packed {
		seg_t seg;
		logic valid;
		logic fresh;    // stored during the current pass, not yet committed
	} entry_t;

	typedef struct packed {
		logic shift;    // rotate the ring one place
		logic commit;   // end of pass: settle fresh entries
		logic keep;     // fresh entries stay valid at commit
	} cell_ctl_t;

	// exact a - b, one bit wider
	function automatic diff_t sub_c(coord_t a, coord_t b);
		return diff_t'({a[CoordW-1], a}) - diff_t'({b[CoordW-1], b});
	endfunction

endpackage

`default_nettype wire

// ----- src/segment_collision_table.sv -----
// ----------------------------------------------------------------------------
// segment_collision_table
// Bounded table of line segments with exact intersection removal.
// ----------------------------------------------------------------------------
// The table slots form a ring of TABLE_DEPTH cells closed through a
// three-stage intersection unit. After a segment transfer the ring makes
// one full turn of TABLE_DEPTH + 3 places so that every stored segment
// passes the unit once; hits are cleared as they leave it, and the new
// segment is tentatively written into the first free slot that goes by. A
// commit state then keeps or discards that write and loads the result
// register. The input is stalled from each transfer until the commit is
// done, so a new segment is not taken before the last one is through. A
// result waiting in the output register does not hold off the next input
// transfer, only the next commit.
`default_nettype none

module segment_collision_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            seg_valid,
	output logic           seg_stall,
	input  sct_pkg::seg_t  seg,
	output logic           res_valid,
	input  wire            res_stall,
	output sct_pkg::res_t  res
);
	import sct_pkg::*;

	localparam int Ring  = TABLE_DEPTH + XLat;
	localparam int CntW  = $clog2(TABLE_DEPTH + 1);
	localparam int PassW = $clog2(Ring);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PASS,
		ST_COMMIT
	} state_t;

	state_t            state_q;
	logic [PassW-1:0]  pass_q;
	logic [CntW-1:0]   count_q;
	logic [CntW-1:0]   removed_q;
	logic              ins_q;
	seg_t              nseg_q;
	diff_t             s1x_q, s1y_q;
	logic              res_valid_q;
	res_t              res_q;

	entry_t            cell_q [TABLE_DEPTH];
	entry_t            leave, tail_in;
	logic              removal;
	logic              ins_now;
	logic              take;
	logic              added;
	cell_ctl_t         cell_ctl;

	assign seg_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign take  = !res_valid_q || !res_stall;
	assign added = ins_q && (removed_q == '0);

	// first free slot leaving the unit after the old bubbles have drained
	assign ins_now = (state_q == ST_PASS) && (pass_q >= PassW'(XLat)) && !ins_q
		&& (removed_q == '0) && (count_q < CntW'(TABLE_DEPTH)) && !leave.valid;

	always_comb begin
		tail_in = leave;
		if (ins_now) begin
			tail_in.seg   = nseg_q;
			tail_in.valid = 1'b1;
			tail_in.fresh = 1'b1;
		end
	end

	assign cell_ctl = '{
		shift:  (state_q == ST_PASS),
		commit: (state_q == ST_COMMIT) && take,
		keep:   (removed_q == '0)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= '0;
			count_q     <= '0;
			removed_q   <= '0;
			ins_q       <= 1'b0;
			nseg_q      <= '0;
			s1x_q       <= '0;
			s1y_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (seg_valid) begin
						nseg_q    <= seg;
						s1x_q     <= sub_c(seg.end_x, seg.start_x);
						s1y_q     <= sub_c(seg.end_y, seg.start_y);
						pass_q    <= '0;
						removed_q <= '0;
						ins_q     <= 1'b0;
						state_q   <= ST_PASS;
					end
				end
				ST_PASS: begin
					if (removal) begin
						removed_q <= removed_q + CntW'(1);
					end
					if (ins_now) begin
						ins_q <= 1'b1;
					end
					if (pass_q == PassW'(Ring - 1)) begin
						state_q <= ST_COMMIT;
					end else begin
						pass_q <= pass_q + PassW'(1);
					end
				end
				ST_COMMIT: begin
					if (take) begin
						count_q                <= count_q - removed_q + CntW'(added);
						res_q.segment_added    <= added;
						res_q.removed_count    <= OutCntW'(removed_q);
						res_q.occupancy        <= OutCntW'(count_q - removed_q + CntW'(added));
						res_q.table_full       <= (removed_q == '0)
							&& (count_q == CntW'(TABLE_DEPTH));
						res_valid_q            <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
			endcase
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_tail
			sct_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (cell_ctl),
				.nxt    (tail_in),
				.q      (cell_q[i])
			);
		end else begin : g_body
			sct_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (cell_ctl),
				.nxt    (cell_q[i+1]),
				.q      (cell_q[i])
			);
		end
	end

	sct_xunit u_xunit (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (cell_ctl.shift),
		.nseg    (nseg_q),
		.s1x     (s1x_q),
		.s1y     (s1y_q),
		.head    (cell_q[0]),
		.leave   (leave),
		.removal (removal)
	);

endmodule

`default_nettype wire

// ----- src/sct_cell.sv -----
// ----------------------------------------------------------------------------
// sct_cell
// One table slot of the ring: holds a segment with its valid and fresh bits
// and takes its neighbor's contents on every rotation step.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sct_pkg::cell_ctl_t  ctl,
	input  sct_pkg::entry_t     nxt,
	output sct_pkg::entry_t     q
);
	import sct_pkg::*;

	seg_t seg_q;
	logic valid_q;
	logic fresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			fresh_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= nxt.valid;
			fresh_q <= nxt.fresh;
		end else if (ctl.commit && fresh_q) begin
			valid_q <= valid_q & ctl.keep;
			fresh_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			seg_q <= nxt.seg;
		end
	end

	assign q = '{seg: seg_q, valid: valid_q, fresh: fresh_q};

endmodule

`default_nettype wire

// ----- src/sct_xunit.sv -----
// ----------------------------------------------------------------------------
// sct_xunit
// Three-stage cross-product intersection unit. Its stage registers are part
// of the ring: every entry leaving the head passes through and comes out
// with its valid bit cleared when it crosses the new segment.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_xunit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 shift,
	input  sct_pkg::seg_t       nseg,
	input  sct_pkg::diff_t      s1x,
	input  sct_pkg::diff_t      s1y,
	input  sct_pkg::entry_t     head,
	output sct_pkg::entry_t     leave,
	output logic                removal
);
	import sct_pkg::*;

	// stage 1: differences
	seg_t  seg_s1;
	logic  vld_s1, frs_s1;
	diff_t s2x_s1, s2y_s1, wx_s1, wy_s1;
	// stage 2: products
	seg_t  seg_s2;
	logic  vld_s2, frs_s2;
	prod_t d1_s2, d2_s2, sn1_s2, sn2_s2, tn1_s2, tn2_s2;
	// stage 3: numerators and denominator
	seg_t  seg_s3;
	logic  vld_s3, frs_s3;
	wide_t d_s3, sn_s3, tn_s3;

	wide_t dn, snn, tnn;
	logic  hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			frs_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			frs_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			frs_s3 <= 1'b0;
		end else if (shift) begin
			vld_s1 <= head.valid;
			frs_s1 <= head.fresh;
			vld_s2 <= vld_s1;
			frs_s2 <= frs_s1;
			vld_s3 <= vld_s2;
			frs_s3 <= frs_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			seg_s1 <= head.seg;
			s2x_s1 <= sub_c(head.seg.end_x, head.seg.start_x);
			s2y_s1 <= sub_c(head.seg.end_y, head.seg.start_y);
			wx_s1  <= sub_c(nseg.start_x, head.seg.start_x);
			wy_s1  <= sub_c(nseg.start_y, head.seg.start_y);

			seg_s2 <= seg_s1;
			d1_s2  <= prod_t'(s1x) * prod_t'(s2y_s1);
			d2_s2  <= prod_t'(s2x_s1) * prod_t'(s1y);
			sn1_s2 <= prod_t'(s1x) * prod_t'(wy_s1);
			sn2_s2 <= prod_t'(s1y) * prod_t'(wx_s1);
			tn1_s2 <= prod_t'(s2x_s1) * prod_t'(wy_s1);
			tn2_s2 <= prod_t'(s2y_s1) * prod_t'(wx_s1);

			seg_s3 <= seg_s2;
			d_s3   <= wide_t'(d1_s2) - wide_t'(d2_s2);
			sn_s3  <= wide_t'(sn1_s2) - wide_t'(sn2_s2);
			tn_s3  <= wide_t'(tn1_s2) - wide_t'(tn2_s2);
		end
	end

	// normalize to a positive denominator, then range-check both parameters
	always_comb begin
		if (d_s3[WideW-1]) begin
			dn  = -d_s3;
			snn = -sn_s3;
			tnn = -tn_s3;
		end else begin
			dn  = d_s3;
			snn = sn_s3;
			tnn = tn_s3;
		end
		hit = (d_s3 != '0) && !snn[WideW-1] && (snn <= dn) && !tnn[WideW-1] && (tnn <= dn);
	end

	assign leave   = '{seg: seg_s3, valid: vld_s3 & ~hit, fresh: frs_s3};
	assign removal = shift & vld_s3 & hit;

endmodule

`default_nettype wire

// ----- verif/tb_segment_collision_table.sv -----
// ----------------------------------------------------------------------------
// tb_segment_collision_table
// Self-checking bench for the segment collision table: a shadow table
// predicts add/remove/occupancy/full for every segment transfer, and each
// result transfer is compared against the oldest prediction. Directed
// geometry and a table fill/overflow sequence run first, then random bursts
// built to fill, sweep and churn the table under varying handshake pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_collision_table;
	import sct_pkg::*;

	localparam int Depth          = 64;
	localparam int HangLimit      = 4000;  // cycles with no transfer on either side
	localparam int RandomPerPhase = 410;
	localparam int DrainCycles    = 2 * Depth;

	typedef enum int {
		BURST_FILL,
		BURST_MIXED,
		BURST_SWEEP,
		BURST_CLUSTER
	} burst_kind_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  seg_valid = 1'b0;
	seg_t  seg       = '0;
	logic  res_stall = 1'b0;
	logic  seg_stall;
	logic  res_valid;
	res_t  res;

	seg_t  shadow_seg [Depth];
	bit    shadow_used [Depth];
	int    shadow_count;
	res_t  due_results [$];

	int    mismatches   = 0;
	int    results_seen = 0;
	int    items_sent   = 0;
	int    quiet_cycles = 0;
	int    idle_pct     = 0;
	int    stall_pct    = 0;

	always #5 clk = ~clk;

	segment_collision_table #(
		.TABLE_DEPTH(Depth)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// exact cross-product test, endpoints touching counts as a hit
	function automatic bit segs_intersect(seg_t a, seg_t b);
		longint s1x, s1y, s2x, s2y, wx, wy, den, sn, tn;
		s1x = longint'(a.end_x) - longint'(a.start_x);
		s1y = longint'(a.end_y) - longint'(a.start_y);
		s2x = longint'(b.end_x) - longint'(b.start_x);
		s2y = longint'(b.end_y) - longint'(b.start_y);
		wx  = longint'(a.start_x) - longint'(b.start_x);
		wy  = longint'(a.start_y) - longint'(b.start_y);
		den = s1x * s2y - s2x * s1y;
		sn  = s1x * wy - s1y * wx;
		tn  = s2x * wy - s2y * wx;
		if (den == 0)
			return 1'b0;
		if (den < 0) begin
			den = -den;
			sn  = -sn;
			tn  = -tn;
		end
		return sn >= 0 && sn <= den && tn >= 0 && tn <= den;
	endfunction

	// updates the shadow table and returns the status the block should report
	function automatic res_t predict_table_step(seg_t s);
		res_t r;
		int   hits;
		bit   added;
		bit   full;
		hits  = 0;
		added = 1'b0;
		full  = 1'b0;
		for (int i = 0; i < Depth; i++) begin
			if (shadow_used[i] && segs_intersect(s, shadow_seg[i])) begin
				shadow_used[i] = 1'b0;
				hits++;
			end
		end
		shadow_count -= hits;
		if (hits == 0) begin
			if (shadow_count >= Depth) begin
				full = 1'b1;
			end else begin
				for (int i = 0; i < Depth; i++) begin
					if (!shadow_used[i] && !added) begin
						shadow_used[i] = 1'b1;
						shadow_seg[i]  = s;
						shadow_count++;
						added = 1'b1;
					end
				end
			end
		end
		r.segment_added = added;
		r.removed_count = OutCntW'(hits);
		r.occupancy     = OutCntW'(shadow_count);
		r.table_full    = full;
		return r;
	endfunction

	function automatic seg_t mk_seg(int sx, int sy, int ex, int ey);
		seg_t s;
		s.start_x = coord_t'(sx);
		s.start_y = coord_t'(sy);
		s.end_x   = coord_t'(ex);
		s.end_y   = coord_t'(ey);
		return s;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		$display("ERROR result %0d: %s expected %0d got %0d", results_seen, what, want, got);
		mismatches++;
	endtask

	// called at a rising edge; returns at the edge where the transfer happens
	task automatic send_seg(seg_t s);
		while ($urandom_range(99) < idle_pct) begin
			seg_valid <= 1'b0;
			@(posedge clk);
		end
		seg_valid <= 1'b1;
		seg       <= s;
		do
			@(posedge clk);
		while (seg_stall);
		items_sent++;
	endtask

	// result checker; the older result is retired before a new prediction
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected transfer, occupancy", -1,
						int'(res.occupancy));
				end else begin
					want = due_results.pop_front();
					if (res.segment_added !== want.segment_added)
						report_mismatch("segment_added", int'(want.segment_added),
							int'(res.segment_added));
					if (res.removed_count !== want.removed_count)
						report_mismatch("removed_count", int'(want.removed_count),
							int'(res.removed_count));
					if (res.occupancy !== want.occupancy)
						report_mismatch("occupancy", int'(want.occupancy),
							int'(res.occupancy));
					if (res.table_full !== want.table_full)
						report_mismatch("table_full", int'(want.table_full),
							int'(res.table_full));
				end
				results_seen++;
			end
			if (seg_valid && !seg_stall)
				due_results.push_back(predict_table_step(seg));
		end
	end

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((seg_valid && !seg_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= HangLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// extremes, parallel, collinear, zero-length and end-point contact
	task automatic test_directed();
		send_seg(mk_seg(-32768, -32768, 32767, 32767));
		send_seg(mk_seg(-32768, 32767, 32767, -32768));   // crosses the diagonal
		send_seg(mk_seg(5, 5, 5, 5));                      // zero length
		send_seg(mk_seg(0, 0, 10, 10));                    // through the point above
		send_seg(mk_seg(5, 5, 20, 20));                    // collinear overlap
		send_seg(mk_seg(0, 1, 10, 11));                    // parallel offset
		send_seg(mk_seg(10, 10, 20, 0));                   // touches an end point
		send_seg(mk_seg(-32768, 0, 32767, 0));
		send_seg(mk_seg(0, -32768, 0, 32767));             // crosses at the origin
		send_seg(mk_seg(32767, 32767, 32767, -32768));
		send_seg(mk_seg(-32768, -32768, -32768, 32767));
		send_seg(mk_seg(-32768, 32767, 32767, 32767));     // corner to corner, touches both
		send_seg(mk_seg(-1, -1, -1, -1));
		send_seg(mk_seg(-1, -2, -1, 2));                   // T contact with a point? no: d is 0
		send_seg(mk_seg(-100, 50, 100, 50));
		send_seg(mk_seg(100, 50, 200, 60));                // shares an end point
		send_seg(mk_seg(-100, 40, 100, 60));               // crosses at one unit apart
		send_seg(mk_seg(32767, -32768, -32768, 32767));
		send_seg(mk_seg(1, 0, 1, 0));
		send_seg(mk_seg(-32768, -32768, -32768, -32768));
		send_seg(mk_seg(32767, 32767, -32768, -32767));
	endtask

	// parallel horizontals fill the table, overflow, then get swept
	task automatic test_full_table();
		int base_y;
		base_y = -30000;
		send_seg(mk_seg(-1000, -32768, -1000, 32767));     // sweep away everything that crosses x = -1000
		send_seg(mk_seg(1000, -32768, 1000, 32767));
		for (int i = 0; i < Depth + 6; i++)
			send_seg(mk_seg(-20000 - i, base_y + 3 * i, 20000 + i, base_y + 3 * i));
		send_seg(mk_seg(0, -32768, 0, 32767));
		for (int i = 0; i < Depth + 3; i++)
			send_seg(mk_seg(-5000 + i, base_y + 3 * i, 5000, base_y + 3 * i));
		// collision while full: hits go, nothing is added
		send_seg(mk_seg(4000, base_y, 4000, base_y + 30));
		send_seg(mk_seg(-32768, base_y + 1, 32767, base_y + 1));
	endtask

	task automatic test_random(int count);
		burst_kind_t kind;
		int          target;
		int          n;
		int          y;
		int          c;
		int          a;
		int          b;
		int          x;
		int          pick [4];
		target = items_sent + count;
		pick   = '{-32768, -1, 0, 32767};
		while (items_sent < target) begin
			kind = burst_kind_t'($urandom_range(3));
			case (kind)
				BURST_FILL: begin
					n = $urandom_range(20, 80);
					repeat (n) begin
						if ($urandom_range(9) == 0) begin
							send_seg(mk_seg(rand_coord(), rand_coord(), rand_coord(),
								rand_coord()));
						end else begin
							y = rand_coord();
							send_seg(mk_seg(rand_coord(), y, rand_coord(), y));
						end
					end
				end
				BURST_SWEEP: begin
					x = rand_coord();
					if ($urandom_range(1) == 0)
						send_seg(mk_seg(x, -32768, x, 32767));
					else
						send_seg(mk_seg(x, rand_coord(), x, rand_coord()));
				end
				BURST_CLUSTER: begin
					n = $urandom_range(10, 30);
					repeat (n) begin
						c = int'($urandom_range(128)) - 64;
						y = int'($urandom_range(128)) - 64;
						send_seg(mk_seg(c + int'($urandom_range(80)) - 40,
							y + int'($urandom_range(80)) - 40,
							c + int'($urandom_range(80)) - 40,
							y + int'($urandom_range(80)) - 40));
					end
				end
				default: begin
					n = $urandom_range(10, 40);
					repeat (n) begin
						c = $urandom_range(99);
						if (c < 50) begin
							send_seg(mk_seg(rand_coord(), rand_coord(), rand_coord(),
								rand_coord()));
						end else if (c < 65) begin
							x = rand_coord();
							y = rand_coord();
							send_seg(mk_seg(x, y, x, y));
						end else if (c < 80) begin
							a = rand_coord();
							b = rand_coord();
							send_seg(mk_seg(a, a, b, b));  // collinear family
						end else begin
							send_seg(mk_seg(pick[2'($urandom_range(3))],
								pick[2'($urandom_range(3))],
								pick[2'($urandom_range(3))],
								pick[2'($urandom_range(3))]));
						end
					end
				end
			endcase
		end
	endtask

	initial begin
		for (int i = 0; i < Depth; i++)
			shadow_used[i] = 1'b0;
		shadow_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 30;
		stall_pct = 85;
		test_directed();
		test_full_table();
		test_random(RandomPerPhase);

		idle_pct  = 85;
		stall_pct = 30;
		test_random(RandomPerPhase);

		idle_pct  = 0;
		stall_pct = 0;
		test_random(RandomPerPhase);

		seg_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
